// ===== rtl/sha2_pkg.sv =====
package sha2_pkg;

   localparam int LenBitsDefault = 64;
   localparam int WordBits = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic [1:0] MODE_224 = 2'd0;
   localparam logic [1:0] MODE_256 = 2'd1;
   localparam logic [1:0] MODE_384 = 2'd2;
   localparam logic [1:0] MODE_512 = 2'd3;

   localparam logic [0:0] REG_MODE = 1'b0;

   localparam logic [63:0] KROUND [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] IV512 [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };
   localparam logic [63:0] IV384 [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   function automatic logic [63:0] iv_word(input logic [1:0] mode, input logic [2:0] idx);
      logic [63:0] r;
      case (mode)
         MODE_224: r = {32'd0, IV384[idx][31:0]};
         MODE_256: r = {32'd0, IV512[idx][63:32]};
         MODE_384: r = IV384[idx];
         default:  r = IV512[idx];
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== rtl/sha2_hash_engine_unit.sv =====
// channel | dir | payload
// req     | in  | tdata message_byte; tuser byte_present; tlast last_byte
// rsp     | out | tdata digest_word, word_index; tlast last_word
// csr     | in  | hash_mode at address 0 (decoded on paddr[2] only)
// a byte is accepted only in the idle state; a full block then runs 64 or 80 rounds
// on the shared round unit and an update step; the last byte adds padding of the
// remaining byte slots, one or two compressions and the emission of the digest words
// reset is synchronous; rsp stalls hold the engine in its output state
module sha2_hash_engine_unit #(
   parameter int LENGTH_COUNTER_BITS = sha2_pkg::LenBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // message_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // digest_word, word_index, zero fill
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LB = LENGTH_COUNTER_BITS;

   sha2_pkg::state_type state_ff, state_in;
   logic [1:0]   mode_ff;
   logic [63:0]  hw_ff [8];
   logic [63:0]  v_ff [8];
   logic [63:0]  win_ff [16];
   logic [7:0]   fill_ff;
   logic [LB-1:0] len_ff;
   logic [6:0]   rnd_ff;
   logic         final_ff;
   logic         padmark_ff;
   logic         second_ff;
   logic [2:0]   widx_ff;
   // set when the block just compressed held the length field
   logic         lenblk_ff;
   logic         pad_phase_end;

   logic         wide, acc, cfg_wr, pad_done;
   logic [7:0]   bsz, lenpos;
   logic [6:0]   nrounds;
   logic [63:0]  w_out, new_a, new_e;
   logic [2:0]   nwords_m1;
   logic [127:0] len128;
   logic [3:0]   bidx;
   logic [7:0]   padbyte;

   assign wide = mode_ff[1];
   assign bsz = wide ? 8'd128 : 8'd64;
   assign lenpos = wide ? 8'd112 : 8'd56;
   assign nrounds = wide ? 7'd80 : 7'd64;
   assign acc = req_tvalid && req_tready;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == sha2_pkg::REG_MODE);
   assign csr_pready = 1'b1;
   assign csr_prdata = {30'd0, mode_ff};
   assign len128 = 128'(len_ff);
   // message bytes shift into the schedule window word that holds them
   assign bidx = wide ? fill_ff[6:3] : fill_ff[5:2];

   always_comb begin
      case (mode_ff)
         sha2_pkg::MODE_224: nwords_m1 = 3'd6;
         sha2_pkg::MODE_384: nwords_m1 = 3'd5;
         default:            nwords_m1 = 3'd7;
      endcase
   end

   sha2_round u_round (
      .wide  (wide),
      .rnd   (rnd_ff),
      .w_in  (win_ff[rnd_ff[3:0]]),
      .va    (v_ff[0]), .vb (v_ff[1]), .vc (v_ff[2]), .vd (v_ff[3]),
      .ve    (v_ff[4]), .vf (v_ff[5]), .vg (v_ff[6]), .vh (v_ff[7]),
      .w2    (win_ff[rnd_ff[3:0] - 4'd2]),
      .w7    (win_ff[rnd_ff[3:0] - 4'd7]),
      .w15   (win_ff[rnd_ff[3:0] - 4'd15]),
      .w16   (win_ff[rnd_ff[3:0]]),
      .w_out (w_out),
      .new_a (new_a),
      .new_e (new_e)
   );

   // padding byte for the current slot
   always_comb begin
      logic [7:0] off;
      off = fill_ff - lenpos;
      if (!padmark_ff) padbyte = 8'h80;
      else if (second_ff || fill_ff < lenpos) padbyte = 8'h00;
      else if (wide) padbyte = len128[8*(8'd15 - off[3:0]) +: 8];
      else padbyte = len128[8*(8'd7 - off[3:0]) +: 8];
   end
   assign pad_done = (fill_ff == bsz - 8'd1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha2_pkg::ST_IDLE:
            if (acc) begin
               if (req_tuser && fill_ff == bsz - 8'd1) state_in = sha2_pkg::ST_ROUND;
               else if (req_tlast) state_in = sha2_pkg::ST_PAD;
            end
         sha2_pkg::ST_ROUND:
            if (rnd_ff == nrounds - 7'd1) state_in = sha2_pkg::ST_UPDATE;
         sha2_pkg::ST_UPDATE:
            if (!final_ff) state_in = sha2_pkg::ST_IDLE;
            else if (padmark_ff && !second_ff && fill_ff == 8'd0 && !pad_phase_end)
               state_in = sha2_pkg::ST_PAD;
            else state_in = pad_phase_end ? sha2_pkg::ST_EMIT : sha2_pkg::ST_PAD;
         sha2_pkg::ST_PAD:
            if (pad_done) state_in = sha2_pkg::ST_ROUND;
         sha2_pkg::ST_EMIT:
            if (rsp_tready && widx_ff == nwords_m1) state_in = sha2_pkg::ST_IDLE;
         default: state_in = sha2_pkg::ST_IDLE;
      endcase
      if (cfg_wr) state_in = sha2_pkg::ST_IDLE;
   end

   always_comb begin
      req_tready = (state_ff == sha2_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == sha2_pkg::ST_EMIT);
      rsp_tdata = {5'd0, widx_ff, hw_ff[widx_ff]};
      rsp_tlast = (widx_ff == nwords_m1);
      pad_phase_end = lenblk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha2_pkg::ST_IDLE;
         mode_ff <= sha2_pkg::MODE_256;
         fill_ff <= '0;
         len_ff <= '0;
         rnd_ff <= '0;
         final_ff <= 1'b0;
         padmark_ff <= 1'b0;
         second_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         widx_ff <= '0;
         for (int i = 0; i < 8; i++) hw_ff[i] <= sha2_pkg::iv_word(sha2_pkg::MODE_256, 3'(i));
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            mode_ff <= csr_pwdata[1:0];
            fill_ff <= '0;
            len_ff <= '0;
            final_ff <= 1'b0;
            padmark_ff <= 1'b0;
            second_ff <= 1'b0;
            lenblk_ff <= 1'b0;
            widx_ff <= '0;
            for (int i = 0; i < 8; i++) hw_ff[i] <= sha2_pkg::iv_word(csr_pwdata[1:0], 3'(i));
         end else begin
            case (state_ff)
               sha2_pkg::ST_IDLE:
                  if (acc) begin
                     final_ff <= req_tlast;
                     if (req_tuser) begin
                        win_ff[bidx] <= {win_ff[bidx][55:0], req_tdata};
                        len_ff <= len_ff + LB'(8);
                        fill_ff <= (fill_ff == bsz - 8'd1) ? 8'd0 : fill_ff + 8'd1;
                     end
                     if (req_tuser && fill_ff == bsz - 8'd1) begin
                        rnd_ff <= '0;
                        for (int i = 0; i < 8; i++) v_ff[i] <= hw_ff[i];
                     end
                  end
               sha2_pkg::ST_PAD: begin
                  win_ff[bidx] <= {win_ff[bidx][55:0], padbyte};
                  padmark_ff <= 1'b1;
                  // marker past the length slot: this block gets zeros only
                  if (!padmark_ff && fill_ff >= lenpos) second_ff <= 1'b1;
                  if (pad_done) begin
                     fill_ff <= '0;
                     rnd_ff <= '0;
                     lenblk_ff <= !(second_ff || (!padmark_ff && fill_ff >= lenpos));
                     for (int i = 0; i < 8; i++) v_ff[i] <= hw_ff[i];
                  end else begin
                     fill_ff <= fill_ff + 8'd1;
                  end
               end
               sha2_pkg::ST_ROUND: begin
                  win_ff[rnd_ff[3:0]] <= w_out;
                  v_ff[0] <= new_a;
                  v_ff[1] <= v_ff[0];
                  v_ff[2] <= v_ff[1];
                  v_ff[3] <= v_ff[2];
                  v_ff[4] <= new_e;
                  v_ff[5] <= v_ff[4];
                  v_ff[6] <= v_ff[5];
                  v_ff[7] <= v_ff[6];
                  rnd_ff <= rnd_ff + 7'd1;
               end
               sha2_pkg::ST_UPDATE: begin
                  for (int i = 0; i < 8; i++)
                     hw_ff[i] <= wide ? hw_ff[i] + v_ff[i]
                                      : {32'd0, hw_ff[i][31:0] + v_ff[i][31:0]};
                  if (final_ff && !lenblk_ff) second_ff <= 1'b0;
               end
               sha2_pkg::ST_EMIT:
                  if (rsp_tready) begin
                     if (widx_ff == nwords_m1) begin
                        widx_ff <= '0;
                        fill_ff <= '0;
                        len_ff <= '0;
                        final_ff <= 1'b0;
                        padmark_ff <= 1'b0;
                        second_ff <= 1'b0;
                        lenblk_ff <= 1'b0;
                        for (int i = 0; i < 8; i++)
                           hw_ff[i] <= sha2_pkg::iv_word(mode_ff, 3'(i));
                     end else begin
                        widx_ff <= widx_ff + 3'd1;
                     end
                  end
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== rtl/sha2_round.sv =====
module sha2_round (
   input  logic        wide,
   input  logic [6:0]  rnd,
   input  logic [63:0] w_in,
   input  logic [63:0] va,
   input  logic [63:0] vb,
   input  logic [63:0] vc,
   input  logic [63:0] vd,
   input  logic [63:0] ve,
   input  logic [63:0] vf,
   input  logic [63:0] vg,
   input  logic [63:0] vh,
   input  logic [63:0] w2,
   input  logic [63:0] w7,
   input  logic [63:0] w15,
   input  logic [63:0] w16,
   output logic [63:0] w_out,
   output logic [63:0] new_a,
   output logic [63:0] new_e
);

   logic [63:0] k64, t1, t2, s0, s1;
   logic [31:0] a32, e32, t1n, t2n, s0n, s1n;

   always_comb begin
      k64 = sha2_pkg::KROUND[rnd];
      if (wide) begin
         s1 = sha2_pkg::rotr64(w2, 19) ^ sha2_pkg::rotr64(w2, 61) ^ (w2 >> 6);
         s0 = sha2_pkg::rotr64(w15, 1) ^ sha2_pkg::rotr64(w15, 8) ^ (w15 >> 7);
         w_out = (rnd < 7'd16) ? w_in : s1 + w7 + s0 + w16;
         t1 = vh + (sha2_pkg::rotr64(ve, 14) ^ sha2_pkg::rotr64(ve, 18) ^
                    sha2_pkg::rotr64(ve, 41)) + ((ve & vf) ^ (~ve & vg)) + k64 + w_out;
         t2 = (sha2_pkg::rotr64(va, 28) ^ sha2_pkg::rotr64(va, 34) ^
               sha2_pkg::rotr64(va, 39)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
         new_a = t1 + t2;
         new_e = vd + t1;
         a32 = '0; e32 = '0; t1n = '0; t2n = '0; s0n = '0; s1n = '0;
      end else begin
         a32 = va[31:0];
         e32 = ve[31:0];
         s1n = sha2_pkg::rotr32(w2[31:0], 17) ^ sha2_pkg::rotr32(w2[31:0], 19) ^
               (w2[31:0] >> 10);
         s0n = sha2_pkg::rotr32(w15[31:0], 7) ^ sha2_pkg::rotr32(w15[31:0], 18) ^
               (w15[31:0] >> 3);
         w_out = (rnd < 7'd16) ? {32'd0, w_in[31:0]}
                               : {32'd0, s1n + w7[31:0] + s0n + w16[31:0]};
         t1n = vh[31:0] + (sha2_pkg::rotr32(e32, 6) ^ sha2_pkg::rotr32(e32, 11) ^
                           sha2_pkg::rotr32(e32, 25)) + ((e32 & vf[31:0]) ^ (~e32 & vg[31:0]))
               + k64[63:32] + w_out[31:0];
         t2n = (sha2_pkg::rotr32(a32, 2) ^ sha2_pkg::rotr32(a32, 13) ^
                sha2_pkg::rotr32(a32, 22)) + ((a32 & vb[31:0]) ^ (a32 & vc[31:0]) ^
                (vb[31:0] & vc[31:0]));
         new_a = {32'd0, t1n + t2n};
         new_e = {32'd0, vd[31:0] + t1n};
         s0 = '0; s1 = '0; t1 = '0; t2 = '0;
      end
   end

endmodule

// ===== rtl/sha2_checker.sv =====
module sha2_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while emitting");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp not held");

   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[66:64] == 3'd0) else $error("first index");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("valid after last");

endmodule

bind sha2_hash_engine_unit sha2_checker u_sha2_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

typedef struct {
   logic [63:0] word;
   logic [2:0]  idx;
   logic        last;
} digest_word_type;

class digest_scoreboard;
   logic [1:0]   mode;
   logic [63:0]  hw[8];
   logic [63:0]  sched[16];
   logic [7:0]   blk[128];
   int           fill;
   logic [63:0]  nbits;
   digest_word_type expected_words[$];
   int           errors;

   function new();
      mode = sha2_pkg::MODE_256;
      errors = 0;
      restart();
   endfunction

   function void restart();
      for (int i = 0; i < 8; i++) begin
         case (mode)
            sha2_pkg::MODE_224: hw[i] = {32'd0, sha2_pkg::IV384[i][31:0]};
            sha2_pkg::MODE_256: hw[i] = {32'd0, sha2_pkg::IV512[i][63:32]};
            sha2_pkg::MODE_384: hw[i] = sha2_pkg::IV384[i];
            default:            hw[i] = sha2_pkg::IV512[i];
         endcase
      end
      fill = 0;
      nbits = '0;
   endfunction

   function void note_config(logic [2:0] addr, logic [31:0] data);
      if (addr == {sha2_pkg::REG_MODE, 2'b00}) begin
         mode = data[1:0];
         restart();
      end
   endfunction

   function logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function logic [63:0] ror64(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function void compress32();
      logic [31:0] v[8];
      logic [31:0] wd, w2, w15, t1, t2, a, e;
      for (int i = 0; i < 8; i++) v[i] = hw[i][31:0];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            wd = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
         end else begin
            w2 = sched[(r-2) & 15][31:0];
            w15 = sched[(r-15) & 15][31:0];
            wd = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + sched[(r-7) & 15][31:0]
                 + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + sched[r & 15][31:0];
         end
         sched[r & 15] = {32'd0, wd};
         a = v[0];
         e = v[4];
         t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
              + sha2_pkg::KROUND[r][63:32] + wd;
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hw[i] = {32'd0, hw[i][31:0] + v[i]};
   endfunction

   function void compress64();
      logic [63:0] v[8];
      logic [63:0] wd, w2, w15, t1, t2, a, e;
      for (int i = 0; i < 8; i++) v[i] = hw[i];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wd = '0;
            for (int k = 0; k < 8; k++) wd = {wd[55:0], blk[8*r+k]};
         end else begin
            w2 = sched[(r-2) & 15];
            w15 = sched[(r-15) & 15];
            wd = (ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6)) + sched[(r-7) & 15]
                 + (ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7)) + sched[r & 15];
         end
         sched[r & 15] = wd;
         a = v[0];
         e = v[4];
         t1 = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & v[5]) ^ (~e & v[6]))
              + sha2_pkg::KROUND[r] + wd;
         t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hw[i] = hw[i] + v[i];
   endfunction

   function void compress();
      if (mode >= sha2_pkg::MODE_384) compress64();
      else compress32();
   endfunction

   function void note_item(logic [7:0] data, logic present, logic last);
      int bs, lenb, n;
      digest_word_type d;
      bs = (mode >= sha2_pkg::MODE_384) ? 128 : 64;
      lenb = (mode >= sha2_pkg::MODE_384) ? 16 : 8;
      if (present) begin
         blk[fill] = data;
         fill++;
         nbits = nbits + 64'd8;
         if (fill >= bs) begin
            compress();
            fill = 0;
         end
      end
      if (!last) return;
      blk[fill] = 8'h80;
      fill++;
      if (fill > bs - lenb) begin
         while (fill < bs) begin
            blk[fill] = 8'h00;
            fill++;
         end
         compress();
         fill = 0;
      end
      while (fill < bs - 8) begin
         blk[fill] = 8'h00;
         fill++;
      end
      for (int k = 0; k < 8; k++) blk[bs-8+k] = nbits[63-8*k -: 8];
      compress();
      case (mode)
         sha2_pkg::MODE_224: n = 7;
         sha2_pkg::MODE_384: n = 6;
         default:            n = 8;
      endcase
      for (int k = 0; k < n; k++) begin
         d.word = hw[k];
         d.idx = k[2:0];
         d.last = (k == n - 1);
         expected_words.push_back(d);
      end
      restart();
   endfunction

   function void check_word(logic [71:0] data, logic last);
      digest_word_type d;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected digest item, expected none, actual %h", $time, data);
         errors++;
         return;
      end
      d = expected_words.pop_front();
      if (data[63:0] !== d.word) begin
         $display("%0t: digest word mismatch, expected %h, actual %h", $time, d.word, data[63:0]);
         errors++;
      end
      if (data[66:64] !== d.idx) begin
         $display("%0t: word index mismatch, expected %0d, actual %0d", $time, d.idx, data[66:64]);
         errors++;
      end
      if (last !== d.last) begin
         $display("%0t: last word mismatch, expected %b, actual %b", $time, d.last, last);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEM_COUNT = 320;
   localparam logic [2:0] ADDR_MODE = {sha2_pkg::REG_MODE, 2'b00};
   localparam logic [2:0] ADDR_SPARE = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   digest_scoreboard sb = new();
   int  items_sent = 0;
   int  cycles = 0;
   bit  calm = 1'b0;
   bit  hold_start = 1'b0;
   bit  hold_used = 1'b0;
   int  hold_left = 0;

   sha2_hash_engine_unit u_dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_start && !hold_used) begin
         hold_used = 1'b1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 38);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(logic [7:0] data, logic present, logic last);
      if (!calm) begin
         while ($urandom_range(0, 99) < 38) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= present;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_item(data, present, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      settle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.note_config(addr, data);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         if (i == len - 1 && $urandom_range(0, 4) != 0)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      if (len == 0 || $urandom_range(0, 4) == 0 && len > 0 && sb.fill == 0 && sb.nbits == 0)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int len, pick;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int m = 0; m < 4; m++) begin
         csr_write(ADDR_MODE, 32'(m));
         send_item(8'h00, 1'b0, 1'b1);
         send_item(8'h00, 1'b1, 1'b0);
         send_item(8'h5a, 1'b0, 1'b0);
         send_item(8'hff, 1'b1, 1'b1);
      end
      csr_write(ADDR_SPARE, 32'h0000_0002);
      send_item(8'haa, 1'b1, 1'b0);
      send_item(8'h55, 1'b1, 1'b0);
      // mode write drops the message in progress
      csr_write(ADDR_MODE, 32'(sha2_pkg::MODE_256));
      send_item(8'h61, 1'b1, 1'b1);

      while (items_sent < ITEM_COUNT) begin
         calm = (items_sent >= 120 && items_sent < 180);
         if (items_sent >= 220) hold_start = 1'b1;
         if ($urandom_range(0, 3) == 0) csr_write(ADDR_MODE, $urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         if (pick < 70) len = $urandom_range(0, 12);
         else if (pick < 90) len = $urandom_range(50, 70);
         else len = $urandom_range(108, 132);
         if (len > ITEM_COUNT - items_sent) len = ITEM_COUNT - items_sent;
         if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            csr_write(ADDR_MODE, $urandom_range(0, 3));
         end else begin
            send_message(len);
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (sb.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== sha2_hash_engine_unit.f =====
rtl/sha2_pkg.sv
rtl/sha2_round.sv
rtl/sha2_hash_engine_unit.sv
rtl/sha2_checker.sv
dv/tb.sv
